>>> rtl/core/pdma_pkg.sv
`default_nettype none

package pdma_pkg;

  localparam int OP_W       = 3;
  localparam int CH_FIELD_W = 2;
  localparam int COUNT_W    = 24;
  localparam int TAG_W      = 8;
  localparam int OFS_W      = 12;
  localparam int MAP_IDX_W  = 8;
  localparam int MAP_W      = 16;
  localparam int REQ_W      = 4;
  localparam int IRQ_W      = 4;
  localparam int ADDR_W     = 28;
  localparam int KIND_W     = 2;
  localparam int CTL_W      = 3;

  localparam logic [OP_W-1:0] OP_CTRL = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
  localparam logic [OP_W-1:0] OP_MAP  = 3'd2;
  localparam logic [OP_W-1:0] OP_PASS = 3'd3;
  localparam logic [OP_W-1:0] OP_STAT = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TO_MEM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TO_DEV = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

  localparam int CTL_EN    = 0;
  localparam int CTL_TOMEM = 1;
  localparam int CTL_APAD  = 2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CH_FIELD_W-1:0] xfer_channel;
    logic [ADDR_W-1:0]     address;
    logic                  pad;
    logic                  halted;
    logic [COUNT_W-1:0]    count_now;
    logic [TAG_W-1:0]      tag_now;
    logic [OFS_W-1:0]      offset_now;
    logic                  done_res;
    logic                  int_out;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/pdma_ram.sv
`default_nettype none

module pdma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/paged_dma_channel_engine.sv
`default_nettype none

// Paged DMA channel engine.
// Command channel: an item is taken on a clock edge with start high and busy
// low. Ops set control, load count/tag/offset, write a page map entry, read
// status, or run a service pass over drq_mask.
// Result channel: each result beat is shown for one cycle with result_valid
// high; the receiver cannot hold it off. last marks the final beat of an item.
// Map write, unused ops, a pass with no requests, and control, load or status
// on an absent channel answer on the cycle after acceptance; other control,
// load and status items answer once the channel record is read from its RAM,
// and control and load also write the record back.
// A service pass handles each requesting channel that transfers with a record
// read, then a page map read with write-back; a channel that halts ends the
// pass after its record read.
// Channel records reset to zero through per-channel valid bits, so no
// clearing pass is needed; the page map is undefined until written.
// Reset is synchronous; busy drops and no result is shown during reset.
module paged_dma_channel_engine #(
  parameter int CHANNELS    = 4,
  parameter int MAP_ENTRIES = 256,
  parameter int PAGE_BITS   = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pdma_pkg::OP_W-1:0]          op,
  input  wire logic [pdma_pkg::CH_FIELD_W-1:0]    channel,
  input  wire logic                               enable,
  input  wire logic                               to_memory,
  input  wire logic                               autopad,
  input  wire logic [pdma_pkg::COUNT_W-1:0]       count,
  input  wire logic [pdma_pkg::TAG_W-1:0]         tag,
  input  wire logic [pdma_pkg::OFS_W-1:0]         offset,
  input  wire logic [pdma_pkg::MAP_IDX_W-1:0]     map_index,
  input  wire logic [pdma_pkg::MAP_W-1:0]         map_value,
  input  wire logic [pdma_pkg::REQ_W-1:0]         drq_mask,
  input  wire logic [pdma_pkg::IRQ_W-1:0]         irq_lines,
  output logic                                    result_valid,
  output logic      [pdma_pkg::KIND_W-1:0]        kind,
  output logic      [pdma_pkg::CH_FIELD_W-1:0]    xfer_channel,
  output logic      [pdma_pkg::ADDR_W-1:0]        address,
  output logic                                    pad,
  output logic                                    halted,
  output logic      [pdma_pkg::COUNT_W-1:0]       count_now,
  output logic      [pdma_pkg::TAG_W-1:0]         tag_now,
  output logic      [pdma_pkg::OFS_W-1:0]         offset_now,
  output logic                                    done_res,
  output logic                                    int_out,
  output logic                                    last
);

  import pdma_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAP_D  = CHANNELS * MAP_ENTRIES;
  localparam int MAP_AW = $clog2(MAP_D);
  localparam int REC_W  = CTL_W + COUNT_W + TAG_W + PAGE_BITS + 1;
  localparam int CNT_LO = CTL_W;
  localparam int TAG_LO = CNT_LO + COUNT_W;
  localparam int OFS_LO = TAG_LO + TAG_W;
  localparam int DONE_B = OFS_LO + PAGE_BITS;
  localparam int FULL_W = MAP_W + PAGE_BITS;
  localparam logic [REQ_W-1:0] REQ_MASK =
    (CHANNELS >= REQ_W) ? {REQ_W{1'b1}} : REQ_W'((1 << CHANNELS) - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_MAP  = 2'd2;

  function automatic logic [TAG_W-1:0] map_slot(input logic [TAG_W-1:0] t);
    logic [11:0] r;
    r = 12'(t);
    for (int k = 3; k >= 0; k--) begin
      if (r >= 12'(MAP_ENTRIES << k)) begin
        r = r - 12'(MAP_ENTRIES << k);
      end
    end
    return TAG_W'(r);
  endfunction

  function automatic logic [CH_FIELD_W-1:0] lowest_req(input logic [REQ_W-1:0] m);
    logic [CH_FIELD_W-1:0] c;
    c = '0;
    priority if (m[0]) c = 2'd0;
    else if (m[1]) c = 2'd1;
    else if (m[2]) c = 2'd2;
    else if (m[3]) c = 2'd3;
    return c;
  endfunction

  logic [1:0]            state, state_next;
  logic [OP_W-1:0]       op_q;
  logic [CH_FIELD_W-1:0] cur, cur_next;
  logic [REQ_W-1:0]      pend, pend_next;
  logic                  enable_q, to_memory_q, autopad_q, irq_q;
  logic [COUNT_W-1:0]    count_q;
  logic [TAG_W-1:0]      tag_q;
  logic [OFS_W-1:0]      offset_q;
  logic [CHANNELS-1:0]   chan_vld;
  logic                  rd_valid;
  res_t                  res, res_next;
  logic                  strobe_next;

  logic                  chan_we, chan_re;
  logic [CH_W-1:0]       chan_waddr, chan_raddr;
  logic [REC_W-1:0]      chan_wdata, chan_rdata, rec;
  logic                  map_we, map_re;
  logic [MAP_AW-1:0]     map_waddr, map_raddr;
  logic [MAP_W-1:0]      map_rdata;

  logic [CTL_W-1:0]      r_ctl;
  logic [COUNT_W-1:0]    r_cnt, cnt_dec;
  logic [TAG_W-1:0]      r_tag, tag_inc;
  logic [PAGE_BITS-1:0]  r_ofs, ofs_inc;
  logic                  r_done, ch_ok, halt_now;
  logic [FULL_W-1:0]     full_addr;
  logic [REQ_W-1:0]      req;
  logic                  irq_now;

  pdma_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS), .AW(CH_W)) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .re    (chan_re),
    .raddr (chan_raddr),
    .rdata (chan_rdata)
  );

  pdma_ram #(.WIDTH(MAP_W), .DEPTH(MAP_D), .AW(MAP_AW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_value),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // unwritten records read as zero
  assign rec    = rd_valid ? chan_rdata : '0;
  assign r_ctl  = rec[CTL_W-1:0];
  assign r_cnt  = rec[TAG_LO-1:CNT_LO];
  assign r_tag  = rec[OFS_LO-1:TAG_LO];
  assign r_ofs  = rec[DONE_B-1:OFS_LO];
  assign r_done = rec[DONE_B];

  assign cnt_dec   = (r_cnt != '0) ? r_cnt - 1'b1 : '0;
  assign ofs_inc   = r_ofs + 1'b1;
  assign tag_inc   = (&r_ofs) ? r_tag + 1'b1 : r_tag;
  assign full_addr = {map_rdata, r_ofs};
  assign halt_now  = !r_ctl[CTL_EN] || (r_cnt == '0 && !r_ctl[CTL_APAD]);

  assign ch_ok   = 32'(channel) < CHANNELS;
  assign req     = drq_mask & REQ_MASK;
  assign irq_now = |irq_lines;
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    pend_next   = pend;
    chan_we     = 1'b0;
    chan_re     = 1'b0;
    chan_waddr  = CH_W'(cur);
    chan_raddr  = CH_W'(cur);
    chan_wdata  = rec;
    map_we      = 1'b0;
    map_re      = 1'b0;
    map_waddr   = MAP_AW'(32'(channel) * MAP_ENTRIES + 32'(map_slot(map_index)));
    map_raddr   = MAP_AW'(32'(cur) * MAP_ENTRIES + 32'(map_slot(r_tag)));
    res_next    = '0;
    res_next.int_out = irq_q;
    res_next.xfer_channel = cur;
    strobe_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        res_next.int_out      = irq_now;
        res_next.xfer_channel = channel;
        res_next.last         = 1'b1;
        if (start) begin
          cur_next = channel;
          unique case (op)
            OP_CTRL, OP_LOAD, OP_STAT: begin
              if (ch_ok) begin
                chan_re    = 1'b1;
                chan_raddr = CH_W'(channel);
                state_next = S_RD;
              end else begin
                strobe_next   = 1'b1;
                res_next.kind = (op == OP_STAT) ? KIND_STATUS : KIND_ACK;
              end
            end
            OP_MAP: begin
              map_we      = ch_ok;
              strobe_next = 1'b1;
            end
            OP_PASS: begin
              if (req == '0) begin
                strobe_next           = 1'b1;
                res_next.xfer_channel = '0;
              end else begin
                cur_next   = lowest_req(req);
                pend_next  = req & (req - 1'b1);
                chan_re    = 1'b1;
                chan_raddr = CH_W'(lowest_req(req));
                state_next = S_RD;
              end
            end
            default: begin
              strobe_next = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        unique case (op_q)
          OP_CTRL: begin
            chan_we     = 1'b1;
            chan_wdata  = {rec[REC_W-1:CTL_W], autopad_q, to_memory_q, enable_q};
            strobe_next = 1'b1;
            res_next.last = 1'b1;
            state_next  = S_IDLE;
          end
          OP_LOAD: begin
            chan_we     = 1'b1;
            chan_wdata  = {1'b0, PAGE_BITS'(offset_q), tag_q, count_q, r_ctl};
            strobe_next = 1'b1;
            res_next.last = 1'b1;
            state_next  = S_IDLE;
          end
          OP_STAT: begin
            strobe_next         = 1'b1;
            res_next.kind       = KIND_STATUS;
            res_next.count_now  = r_cnt;
            res_next.tag_now    = r_tag;
            res_next.offset_now = OFS_W'(r_ofs);
            res_next.done_res   = r_done;
            res_next.last       = 1'b1;
            state_next          = S_IDLE;
          end
          OP_PASS: begin
            if (halt_now) begin
              strobe_next     = 1'b1;
              res_next.halted = 1'b1;
              res_next.last   = 1'b1;
              state_next      = S_IDLE;
            end else begin
              map_re     = 1'b1;
              state_next = S_MAP;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_MAP: begin
        strobe_next      = 1'b1;
        res_next.kind    = r_ctl[CTL_TOMEM] ? KIND_TO_MEM : KIND_TO_DEV;
        res_next.address = ADDR_W'(full_addr);
        res_next.pad     = (r_cnt == '0);
        res_next.last    = (pend == '0);
        chan_we    = 1'b1;
        chan_wdata = {r_done | (cnt_dec == '0), ofs_inc, tag_inc, cnt_dec, r_ctl};
        if (pend == '0) begin
          state_next = S_IDLE;
        end else begin
          cur_next   = lowest_req(pend);
          pend_next  = pend & (pend - 1'b1);
          chan_re    = 1'b1;
          chan_raddr = CH_W'(lowest_req(pend));
          state_next = S_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      chan_vld     <= '0;
      rd_valid     <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= strobe_next;
      if (chan_we) begin
        chan_vld[chan_waddr] <= 1'b1;
      end
      if (chan_re) begin
        rd_valid <= chan_vld[chan_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    pend <= pend_next;
    res  <= res_next;
    if (start && !busy) begin
      op_q        <= op;
      enable_q    <= enable;
      to_memory_q <= to_memory;
      autopad_q   <= autopad;
      count_q     <= count;
      tag_q       <= tag;
      offset_q    <= offset;
      irq_q       <= irq_now;
    end
  end

  assign kind         = res.kind;
  assign xfer_channel = res.xfer_channel;
  assign address      = res.address;
  assign pad          = res.pad;
  assign halted       = res.halted;
  assign count_now    = res.count_now;
  assign tag_now      = res.tag_now;
  assign offset_now   = res.offset_now;
  assign done_res     = res.done_res;
  assign int_out      = res.int_out;
  assign last         = res.last;

endmodule

`default_nettype wire

>>> rtl/core/pdma_checker.sv
`default_nettype none

module pdma_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [pdma_pkg::OP_W-1:0]       op,
  input wire logic                            result_valid,
  input wire logic [pdma_pkg::KIND_W-1:0]     kind,
  input wire logic                            pad,
  input wire logic                            halted,
  input wire logic                            last
);

  import pdma_pkg::*;

  // a halt beat always closes the pass
  a_halt_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && halted |-> last && kind == KIND_ACK)
    else $error("halt beat not final");

  // pad only on transfer beats
  a_pad_xfer: assert property (@(posedge clk) disable iff (rst)
    result_valid && pad |-> kind == KIND_TO_MEM || kind == KIND_TO_DEV)
    else $error("pad on non-transfer beat");

  // more beats to come keeps the engine busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("idle with pass unfinished");

  // map writes answer with one acknowledge on the next cycle
  a_map_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_MAP |=> result_valid && last && kind == KIND_ACK)
    else $error("map write not acknowledged");

  // status beats are single
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_STATUS |-> last)
    else $error("status beat not final");

endmodule

bind paged_dma_channel_engine pdma_checker u_pdma_checker (.*);

`default_nettype wire
